// File: sv/dwta_pkg.sv
package dwta_pkg;

    localparam int MAX_PIECES = 64;
    localparam int IDX_W      = $clog2(MAX_PIECES);
    localparam int CNT_W      = $clog2(MAX_PIECES + 1);
    localparam int MCNT_W     = $clog2(2 * MAX_PIECES + 2);
    localparam int RAM_DEPTH  = 2 ** (IDX_W + 1);

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam int TW         = 35;
    localparam int STEP_W     = 6;
    localparam logic [STEP_W-1:0] XFER_STEPS = 6'd32;
    localparam logic [STEP_W-1:0] UTIL_STEPS = 6'd16;
    localparam logic [16:0] UTIL_ONE = 17'h10000;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HARR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HDL   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic signed [TW-1:0] t_time;

    typedef struct packed {
        logic [31:0] harr;
        logic [31:0] hdep;
        logic [15:0] speed;
        logic [15:0] hul;
        logic [15:0] hdl;
    } t_cfg;

    typedef struct packed {
        logic        commit;
        logic [15:0] owner;
        t_time       strt;
        t_time       endd;
        logic [31:0] ex;
    } t_job;

    typedef struct packed {
        logic [15:0] own;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] wlo;
        logic [31:0] whi;
    } t_piece;

    // A rate of zero behaves as one bit per second.
    function automatic logic [31:0] rate_fix(input logic [15:0] rate);
        rate_fix = (rate == 16'd0) ? 32'd1 : {16'd0, rate};
    endfunction

endpackage

// File: sv/dwta_if.sv
interface dwta_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] owner_tag;
    logic [31:0] client_arrival;
    logic [15:0] task_bits;
    logic [15:0] result_bits;
    logic [31:0] deadline;
    logic [15:0] client_uplink;
    logic [15:0] client_downlink;

    modport source(output valid, req_type, owner_tag, client_arrival, task_bits,
                   result_bits, deadline, client_uplink, client_downlink,
                   input ready);
    modport sink(input valid, req_type, owner_tag, client_arrival, task_bits,
                 result_bits, deadline, client_uplink, client_downlink,
                 output ready);
endinterface

interface dwta_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] completion_time;
    logic [16:0] utilization;

    modport source(output valid, status, completion_time, utilization, input ready);
    modport sink(input valid, status, completion_time, utilization, output ready);
endinterface

// File: sv/dwta_ram.sv
module dwta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/dwta_div.sv
module dwta_div import dwta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_rem0,
    input  logic [31:0]       i_dvd,
    input  logic [31:0]       i_dsr,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_done,
    output logic [31:0]       o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [31:0]       r_rem;
    logic [31:0]       r_dvd;
    logic [31:0]       r_dsr;
    logic [31:0]       r_quo;
    logic [32:0]       w_trial;
    logic [32:0]       w_diff;
    logic              w_ge;

    // Restoring division, one quotient bit per cycle. The starting remainder
    // must be below the divisor.
    assign w_trial = {r_rem, r_dvd[31]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_dvd <= i_dvd;
            r_dsr <= i_dsr;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: sv/dwta_front.sv
module dwta_front import dwta_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    dwta_req_if.sink   i_req,
    output logic       o_jvalid,
    input  logic       i_jready,
    output t_job       o_job
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_LOAD = 5'b00010,
        F_WAIT = 5'b00100,
        F_CALC = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    typedef enum logic [2:0] {
        X_EX  = 3'd0,
        X_HDL = 3'd1,
        X_CU  = 3'd2,
        X_HUL = 3'd3,
        X_CD  = 3'd4
    } t_xop;

    t_fstate     r_state;
    t_xop        r_op;
    logic        r_commit;
    logic [15:0] r_owner;
    logic [31:0] r_carr;
    logic [15:0] r_tb;
    logic [15:0] r_rb;
    logic [31:0] r_dl;
    logic [15:0] r_cu;
    logic [15:0] r_cd;
    logic [31:0] r_ex;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_c;
    logic [31:0] r_d;
    t_job        r_job;

    logic [31:0] w_dvd;
    logic [31:0] w_dsr;
    logic        w_done;
    logic [31:0] w_quo;
    t_time       w_s1, w_s2, w_e1, w_e2;

    always_comb begin
        case (r_op)
            X_EX:    begin w_dvd = {r_tb, 16'd0}; w_dsr = rate_fix(i_cfg.speed); end
            X_HDL:   begin w_dvd = {r_tb, 16'd0}; w_dsr = rate_fix(i_cfg.hdl);   end
            X_CU:    begin w_dvd = {r_tb, 16'd0}; w_dsr = rate_fix(r_cu);        end
            X_HUL:   begin w_dvd = {r_rb, 16'd0}; w_dsr = rate_fix(i_cfg.hul);   end
            X_CD:    begin w_dvd = {r_rb, 16'd0}; w_dsr = rate_fix(r_cd);        end
            default: begin w_dvd = {r_tb, 16'd0}; w_dsr = rate_fix(i_cfg.speed); end
        endcase
    end

    dwta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == F_LOAD),
        .i_rem0  (32'd0),
        .i_dvd   (w_dvd),
        .i_dsr   (w_dsr),
        .i_steps (XFER_STEPS),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    // Window start: input has crossed both links. Window end: result can
    // still return before the deadline and before the host leaves.
    assign w_s1 = {3'd0, i_cfg.harr} + {3'd0, r_a};
    assign w_s2 = {3'd0, r_carr} + {3'd0, r_b} + {3'd0, r_a};
    assign w_e1 = {3'd0, r_dl} - {3'd0, r_c} - {3'd0, r_d};
    assign w_e2 = {3'd0, i_cfg.hdep} - {3'd0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_op    <= X_EX;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= F_LOAD;
                        r_op    <= X_EX;
                    end
                end
                F_LOAD: r_state <= F_WAIT;
                F_WAIT: begin
                    if (w_done) begin
                        if (r_op == X_CD) begin
                            r_state <= F_CALC;
                        end else begin
                            r_op    <= t_xop'(3'(r_op + 3'd1));
                            r_state <= F_LOAD;
                        end
                    end
                end
                F_CALC: r_state <= F_PUSH;
                F_PUSH: begin
                    if (i_jready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_req.valid) begin
            r_commit <= i_req.req_type;
            r_owner  <= i_req.owner_tag;
            r_carr   <= i_req.client_arrival;
            r_tb     <= i_req.task_bits;
            r_rb     <= i_req.result_bits;
            r_dl     <= i_req.deadline;
            r_cu     <= i_req.client_uplink;
            r_cd     <= i_req.client_downlink;
        end
        if (r_state == F_WAIT && w_done) begin
            case (r_op)
                X_EX:    r_ex <= w_quo;
                X_HDL:   r_a  <= w_quo;
                X_CU:    r_b  <= w_quo;
                X_HUL:   r_c  <= w_quo;
                X_CD:    r_d  <= w_quo;
                default: r_ex <= w_quo;
            endcase
        end
        if (r_state == F_CALC) begin
            r_job.commit <= r_commit;
            r_job.owner  <= r_owner;
            r_job.strt   <= (w_s1 > w_s2) ? w_s1 : w_s2;
            r_job.endd   <= (w_e1 < w_e2) ? w_e1 : w_e2;
            r_job.ex     <= r_ex;
        end
    end

    assign i_req.ready = (r_state == F_IDLE);
    assign o_jvalid    = (r_state == F_PUSH);
    assign o_job       = r_job;

endmodule

// File: sv/dwta_fifo.sv
module dwta_fifo import dwta_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wvalid,
    output logic o_wready,
    input  t_job i_wdata,
    output logic o_rvalid,
    input  logic i_rready,
    output t_job o_rdata
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_wready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_rvalid = (r_cnt != '0);
    assign w_push   = i_wvalid && o_wready;
    assign w_pop    = i_rready && o_rvalid;
    assign o_rdata  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// File: sv/dwta_back.sv
module dwta_back import dwta_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_jvalid,
    output logic        o_jready,
    input  t_job        i_job,
    dwta_rsp_if.source  o_rsp
);

    typedef enum logic [9:0] {
        B_IDLE = 10'b0000000001,
        B_INIT = 10'b0000000010,
        B_RD   = 10'b0000000100,
        B_SHF  = 10'b0000001000,
        B_GAP  = 10'b0000010000,
        B_PUT  = 10'b0000100000,
        B_TAIL = 10'b0001000000,
        B_FIN  = 10'b0010000000,
        B_UDIV = 10'b0100000000,
        B_OUT  = 10'b1000000000
    } t_bstate;

    t_bstate     r_state;
    t_job        r_job;
    logic        r_bank;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_k;
    logic [MCNT_W-1:0] r_widx;
    logic        r_ok;
    logic        r_fill;
    t_time       r_top;
    logic [31:0] r_rem;
    logic [31:0] r_prevlo;
    logic        r_have_prev;
    t_piece      r_cand;
    logic [32:0] r_busy;
    logic        r_first;
    logic [31:0] r_comp;
    logic [1:0]  r_status;
    logic [16:0] r_util;
    logic        r_ovalid;
    logic [1:0]  r_ostatus;
    logic [31:0] r_ocomp;
    logic [16:0] r_outil;

    t_piece      w_rd;
    logic [$bits(t_piece)-1:0] w_rd_raw;
    logic [31:0] w_wl, w_wh, w_lim, w_nlc;
    logic signed [33:0] w_nl;
    logic        w_keep;
    t_time       w_gl, w_gh, w_glen, w_rem_t, w_flo;
    logic        w_gap_ok, w_take_all;
    logic [31:0] w_rem_next;
    t_piece      w_fresh;
    logic        w_we;
    t_piece      w_wdata;
    logic        w_room;
    logic signed [TW:0] w_span;
    logic        w_ok;
    logic [1:0]  w_status;
    logic [33:0] w_busy_tot;
    logic [31:0] w_comp;
    logic        w_div_start;
    logic        w_done;
    logic [31:0] w_quo;
    logic        w_last;
    logic        w_load;

    // The store is two banks of one memory: the current schedule is read
    // from one bank while the new schedule is built in the other. Entries
    // are kept latest first.
    dwta_ram #(.WIDTH($bits(t_piece)), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({~r_bank, r_widx[IDX_W-1:0]}),
        .i_wdata (w_wdata),
        .i_raddr ({r_bank, r_k[IDX_W-1:0]}),
        .o_rdata (w_rd_raw)
    );
    assign w_rd = t_piece'(w_rd_raw);

    // Push one stored piece as late as its window and the later piece allow.
    always_comb begin
        w_wl   = (w_rd.wlo > i_cfg.harr) ? w_rd.wlo : i_cfg.harr;
        w_wh   = (w_rd.whi < i_cfg.hdep) ? w_rd.whi : i_cfg.hdep;
        w_lim  = (r_have_prev && r_prevlo < w_wh) ? r_prevlo : w_wh;
        w_nl   = $signed({2'd0, w_rd.lo}) + $signed({2'd0, w_lim})
               - $signed({2'd0, w_rd.hi});
        w_nlc  = (w_nl < 0) ? 32'd0 : w_nl[31:0];
        w_keep = w_nlc < w_lim;
    end

    // Gap below the current top; filled from its upper end.
    always_comb begin
        if (r_state == B_GAP && $signed({3'd0, r_cand.hi}) > r_job.strt) begin
            w_gl = {3'd0, r_cand.hi};
        end else begin
            w_gl = r_job.strt;
        end
        w_gh       = r_top;
        w_gap_ok   = r_fill && (r_rem != 32'd0) && (w_gl < w_gh);
        w_glen     = w_gh - w_gl;
        w_rem_t    = {3'd0, r_rem};
        w_take_all = w_glen >= w_rem_t;
        w_flo      = w_take_all ? (w_gh - w_rem_t) : w_gl;
        w_rem_next = w_take_all ? 32'd0 : (r_rem - w_glen[31:0]);
        w_fresh.own = r_job.owner;
        w_fresh.lo  = w_flo[31:0];
        w_fresh.hi  = w_gh[31:0];
        w_fresh.wlo = r_job.strt[31:0];
        w_fresh.whi = r_job.endd[31:0];
    end

    assign w_room = r_widx < MCNT_W'(MAX_PIECES);

    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_cand;
        if (r_state == B_GAP || r_state == B_TAIL) begin
            w_we    = w_gap_ok && w_room;
            w_wdata = w_fresh;
        end else if (r_state == B_PUT) begin
            w_we    = w_room;
        end
    end

    // Fit test: an empty store allows an exact fit.
    assign w_span = $signed({r_job.endd[TW-1], r_job.endd})
                  - $signed({r_job.strt[TW-1], r_job.strt});
    always_comb begin
        if (r_job.strt >= r_job.endd) begin
            w_ok = 1'b0;
        end else if (r_cnt == '0) begin
            w_ok = w_span >= $signed({(TW-31)'(0), r_job.ex});
        end else begin
            w_ok = w_span > $signed({(TW-31)'(0), r_job.ex});
        end
    end

    always_comb begin
        if (!r_ok || (r_fill && r_rem != 32'd0)) begin
            w_status = ST_NOFIT;
        end else if (r_widx > MCNT_W'(MAX_PIECES)) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_OK;
        end
        w_busy_tot = (w_status == ST_OK && r_fill) ? ({1'b0, r_busy} + {2'd0, r_job.ex})
                                                   : {1'b0, r_busy};
        if (w_status != ST_OK) begin
            w_comp = 32'd0;
        end else if (r_fill) begin
            w_comp = r_comp;
        end else begin
            w_comp = r_job.endd[31:0];
        end
        w_div_start = (r_state == B_FIN) && (i_cfg.hdep != 32'd0)
                   && (w_busy_tot < {2'd0, i_cfg.hdep});
    end

    dwta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem0  (w_busy_tot[31:0]),
        .i_dvd   (32'd0),
        .i_dsr   (i_cfg.hdep),
        .i_steps (UTIL_STEPS),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    assign w_last = (r_k + 1'b1) == r_cnt;
    assign w_load = (r_state == B_OUT) && (!r_ovalid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_bank   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_jvalid) begin
                        r_state <= B_INIT;
                    end
                end
                B_INIT: r_state <= (r_cnt == '0) ? B_TAIL : B_RD;
                B_RD:   r_state <= B_SHF;
                B_SHF: begin
                    if (w_keep) begin
                        r_state <= B_GAP;
                    end else begin
                        r_state <= w_last ? B_TAIL : B_RD;
                    end
                end
                B_GAP:  r_state <= B_PUT;
                B_PUT:  r_state <= w_last ? B_TAIL : B_RD;
                B_TAIL: r_state <= B_FIN;
                B_FIN: begin
                    r_state <= w_div_start ? B_UDIV : B_OUT;
                    if (w_status == ST_OK && r_job.commit) begin
                        r_bank <= ~r_bank;
                        r_cnt  <= r_widx[CNT_W-1:0];
                    end
                end
                B_UDIV: begin
                    if (w_done) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (w_load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (i_jvalid) begin
                    r_job <= i_job;
                end
            end
            B_INIT: begin
                r_ok        <= w_ok;
                r_fill      <= w_ok && (r_job.ex != 32'd0);
                r_top       <= r_job.endd;
                r_rem       <= r_job.ex;
                r_k         <= '0;
                r_widx      <= '0;
                r_have_prev <= 1'b0;
                r_busy      <= '0;
                r_first     <= 1'b0;
                r_comp      <= '0;
            end
            B_SHF: begin
                r_cand.own <= w_rd.own;
                r_cand.lo  <= w_nlc;
                r_cand.hi  <= w_lim;
                r_cand.wlo <= w_wl;
                r_cand.whi <= w_wh;
                if (!w_keep) begin
                    r_k <= r_k + 1'b1;
                end
            end
            B_GAP, B_TAIL: begin
                if (w_gap_ok) begin
                    r_widx <= r_widx + 1'b1;
                    r_rem  <= w_rem_next;
                    if (!r_first) begin
                        r_first <= 1'b1;
                        r_comp  <= w_gh[31:0];
                    end
                end
            end
            B_PUT: begin
                r_widx      <= r_widx + 1'b1;
                r_prevlo    <= r_cand.lo;
                r_have_prev <= 1'b1;
                r_busy      <= r_busy + {1'b0, r_cand.hi - r_cand.lo};
                if ($signed({3'd0, r_cand.lo}) < r_top) begin
                    r_top <= {3'd0, r_cand.lo};
                end
                r_k <= r_k + 1'b1;
            end
            B_FIN: begin
                r_status <= w_status;
                r_comp   <= w_comp;
                if (i_cfg.hdep == 32'd0) begin
                    r_util <= 17'd0;
                end else begin
                    r_util <= UTIL_ONE;
                end
            end
            B_UDIV: begin
                if (w_done) begin
                    r_util <= {1'b0, w_quo[15:0]};
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_ostatus <= r_status;
            r_ocomp   <= r_comp;
            r_outil   <= r_util;
        end
    end

    assign o_jready              = (r_state == B_IDLE);
    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.status          = r_ostatus;
    assign o_rsp.completion_time = r_ocomp;
    assign o_rsp.utilization     = r_outil;

endmodule

// File: sv/deadline_window_task_admission_top.sv
// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   req_type, owner_tag, client_arrival, task_bits,
//                              result_bits, deadline, client_uplink, client_downlink
// o_rsp     out  valid/ready   status, completion_time, utilization
// i_cfg_*   in   write enable  i_cfg_idx selects the register, i_cfg_data holds it
//
// The front end runs five transfer-time divisions one after another on a
// bit-serial divider and takes no new request until its job is queued.
// The back end walks the store, then may run the 16-step utilization divider.
// A two-entry queue lets the two ends overlap.
// Reset is synchronous and clears the piece count; the store needs no clearing pass.
// A finished result waits in the output register while the next request proceeds.
module deadline_window_task_admission_top import dwta_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dwta_req_if.sink             i_req,
    dwta_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    t_cfg r_cfg;
    logic w_fvalid;
    logic w_fready;
    t_job w_fjob;
    logic w_bvalid;
    logic w_bready;
    t_job w_bjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.harr  <= 32'd0;
            r_cfg.hdep  <= 32'd0;
            r_cfg.speed <= 16'd100;
            r_cfg.hul   <= 16'd10000;
            r_cfg.hdl   <= 16'd5000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HARR:  r_cfg.harr  <= i_cfg_data;
                CFG_HDEP:  r_cfg.hdep  <= i_cfg_data;
                CFG_SPEED: r_cfg.speed <= i_cfg_data[15:0];
                CFG_HUL:   r_cfg.hul   <= i_cfg_data[15:0];
                CFG_HDL:   r_cfg.hdl   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dwta_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_req    (i_req),
        .o_jvalid (w_fvalid),
        .i_jready (w_fready),
        .o_job    (w_fjob)
    );

    dwta_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wvalid (w_fvalid),
        .o_wready (w_fready),
        .i_wdata  (w_fjob),
        .o_rvalid (w_bvalid),
        .i_rready (w_bready),
        .o_rdata  (w_bjob)
    );

    dwta_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_jvalid (w_bvalid),
        .o_jready (w_bready),
        .i_job    (w_bjob),
        .o_rsp    (o_rsp)
    );

endmodule

// File: dv/dwta_checker.sv
module dwta_checker import dwta_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dwta_req_if.sink             i_req,
    dwta_rsp_if.sink             i_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct {
        longint lo;
        longint hi;
        longint wlo;
        longint whi;
        logic [15:0] own;
    } seg_s;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] comp;
        logic [16:0] util;
    } verdict_s;

    logic [31:0] h_arr, h_dep;
    logic [15:0] h_speed, h_ul, h_dl;
    seg_s        sched[$];
    verdict_s    verdict_q[$];

    function automatic longint xfer_time(longint bits, logic [15:0] rate);
        longint r;
        r = (rate == 0) ? 1 : longint'(rate);
        return (bits << 16) / r;
    endfunction

    function automatic logic [16:0] busy_fraction(seg_s s[$]);
        longint busy;
        longint u;
        busy = 0;
        if (s.size() == 0 || h_dep == 0) return 0;
        foreach (s[k]) busy += s[k].hi - s[k].lo;
        u = (busy << 16) / longint'(h_dep);
        return (u > 65536) ? 17'h10000 : u[16:0];
    endfunction

    function automatic verdict_s admit_task(
        logic commit, logic [15:0] owner, logic [31:0] carr, logic [15:0] tb,
        logic [15:0] rb, logic [31:0] dl, logic [15:0] cu, logic [15:0] cd);
        longint ex, strt, endd, cur, rem, comp, wl, wh, lim, nl, a, b, len;
        seg_s shifted[$];
        seg_s gaps[$];
        seg_s fresh[$];
        seg_s merged[$];
        seg_s g, t;
        bit ok;
        int j;
        verdict_s v;
        comp = 0;
        ex = xfer_time(tb, h_speed);
        a = longint'(h_arr) + xfer_time(tb, h_dl);
        b = longint'(carr) + xfer_time(tb, cu) + xfer_time(tb, h_dl);
        strt = (a > b) ? a : b;
        a = longint'(dl) - xfer_time(rb, h_ul) - xfer_time(rb, cd);
        b = longint'(h_dep) - xfer_time(rb, cd);
        endd = (a < b) ? a : b;
        // Stored pieces slide late, latest first; each is bounded by its successor.
        for (int i = sched.size() - 1; i >= 0; i--) begin
            wl = (sched[i].wlo > h_arr) ? sched[i].wlo : longint'(h_arr);
            wh = (sched[i].whi < h_dep) ? sched[i].whi : longint'(h_dep);
            lim = wh;
            if (shifted.size() > 0 && shifted[0].lo < lim) lim = shifted[0].lo;
            nl = sched[i].lo + (lim - sched[i].hi);
            if (nl < 0) nl = 0;
            if (nl < lim) begin
                g.lo = nl; g.hi = lim; g.wlo = wl; g.whi = wh; g.own = sched[i].own;
                shifted.push_front(g);
            end
        end
        ok = (strt < endd) &&
             ((sched.size() == 0) ? (endd - strt >= ex) : (endd - strt > ex));
        if (ok && ex > 0) begin
            cur = strt;
            for (int i = 0; i < shifted.size() && cur < endd; i++) begin
                if (shifted[i].lo > cur) begin
                    g.lo = cur;
                    g.hi = (shifted[i].lo < endd) ? shifted[i].lo : endd;
                    gaps.insert(gaps.size(), g);
                end
                if (shifted[i].hi > cur) cur = shifted[i].hi;
            end
            if (cur < endd) begin
                g.lo = cur; g.hi = endd;
                gaps.insert(gaps.size(), g);
            end
            rem = ex;
            for (int i = gaps.size() - 1; i >= 0 && rem > 0; i--) begin
                len = gaps[i].hi - gaps[i].lo;
                g.hi = gaps[i].hi;
                if (len >= rem) begin
                    g.lo = gaps[i].hi - rem;
                    rem = 0;
                end else begin
                    g.lo = gaps[i].lo;
                    rem -= len;
                end
                g.wlo = strt; g.whi = endd; g.own = owner;
                fresh.insert(fresh.size(), g);
            end
            if (rem > 0) ok = 0;
            else comp = fresh[0].hi;
        end else if (ok) begin
            comp = endd;
        end
        if (!ok || shifted.size() + fresh.size() > MAX_PIECES) begin
            v.status = ok ? ST_FULL : ST_NOFIT;
            v.comp = 0;
            v.util = busy_fraction(shifted);
            return v;
        end
        merged = shifted;
        foreach (fresh[i]) merged.insert(merged.size(), fresh[i]);
        for (int i = 1; i < merged.size(); i++) begin
            t = merged[i];
            j = i - 1;
            while (j >= 0 && (merged[j].lo > t.lo ||
                              (merged[j].lo == t.lo && merged[j].hi > t.hi))) begin
                merged[j + 1] = merged[j];
                j--;
            end
            merged[j + 1] = t;
        end
        v.status = ST_OK;
        v.comp = comp[31:0];
        v.util = busy_fraction(merged);
        if (commit) begin
            // Stored fields are 32 bits wide.
            foreach (merged[i]) begin
                merged[i].lo = merged[i].lo & 64'hFFFFFFFF;
                merged[i].hi = merged[i].hi & 64'hFFFFFFFF;
                merged[i].wlo = merged[i].wlo & 64'hFFFFFFFF;
                merged[i].whi = merged[i].whi & 64'hFFFFFFFF;
            end
            sched = merged;
        end
        return v;
    endfunction

    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        verdict_s exp_v;
        if (!i_rst_n) begin
            h_arr <= 0; h_dep <= 0; h_speed <= 100; h_ul <= 10000; h_dl <= 5000;
            sched.delete();
            verdict_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HARR:  h_arr <= i_cfg_data;
                    CFG_HDEP:  h_dep <= i_cfg_data;
                    CFG_SPEED: h_speed <= i_cfg_data[15:0];
                    CFG_HUL:   h_ul <= i_cfg_data[15:0];
                    CFG_HDL:   h_dl <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready)
                verdict_q.insert(verdict_q.size(), admit_task(i_req.req_type,
                    i_req.owner_tag, i_req.client_arrival, i_req.task_bits,
                    i_req.result_bits, i_req.deadline, i_req.client_uplink,
                    i_req.client_downlink));
            if (i_rsp.valid && i_rsp.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected response status=%0d comp=%h util=%h",
                             $time, i_rsp.status, i_rsp.completion_time,
                             i_rsp.utilization);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (exp_v.status !== i_rsp.status ||
                        exp_v.comp !== i_rsp.completion_time ||
                        exp_v.util !== i_rsp.utilization) begin
                        $display("%0t: expected status=%0d comp=%h util=%h, got %0d %h %h",
                                 $time, exp_v.status, exp_v.comp, exp_v.util,
                                 i_rsp.status, i_rsp.completion_time, i_rsp.utilization);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// File: dv/deadline_window_task_admission_top_test.sv
module deadline_window_task_admission_top_test;
    import dwta_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_HARR;
    logic [31:0]          i_cfg_data = 0;
    int                   errors, pending;
    int                   idle_cycles;
    bit                   calm;

    dwta_req_if req_ch();
    dwta_rsp_if rsp_ch();

    deadline_window_task_admission_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data));

    dwta_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .i_rsp(rsp_ch.sink),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending));

    always #6 i_clk = ~i_clk;

    // Receiver stalls about a third of the time, except during calm stretches.
    always @(posedge i_clk)
        rsp_ch.ready <= calm || ($urandom_range(99) >= 34);

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && idle_cycles > STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send_task(logic commit, logic [15:0] id, logic [31:0] carr,
                             logic [15:0] tb, logic [15:0] rb, logic [31:0] dl,
                             logic [15:0] cu, logic [15:0] cd);
        while (!calm && $urandom_range(99) < 34) @(posedge i_clk);
        req_ch.valid <= 1; req_ch.req_type <= commit; req_ch.owner_tag <= id;
        req_ch.client_arrival <= carr; req_ch.task_bits <= tb;
        req_ch.result_bits <= rb; req_ch.deadline <= dl;
        req_ch.client_uplink <= cu; req_ch.client_downlink <= cd;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        req_ch.valid <= 0;
        // The front end is busy after a transaction anyway.
        @(posedge i_clk);
    endtask

    // Mostly feasible tasks on a host living in [harr, hdep].
    task automatic send_random(logic [31:0] harr, logic [31:0] hdep);
        logic [31:0] carr, dl;
        logic [15:0] tb, rb;
        int sel;
        sel = $urandom_range(99);
        carr = harr + $urandom_range(32'h0008_0000);
        tb = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(400));
        rb = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2000));
        dl = carr + $urandom_range(32'h0100_0000);
        if (sel < 10) begin
            carr = $urandom; dl = $urandom;
        end
        send_task($urandom_range(99) < 75, 16'($urandom), carr, tb, rb, dl,
                  sel < 15 ? 16'($urandom) : 16'($urandom_range(65535, 2000)),
                  sel < 15 ? 16'($urandom) : 16'($urandom_range(65535, 2000)));
    endtask

    initial begin
        logic [31:0] harr, hdep;
        req_ch.valid = 0; req_ch.req_type = 0; req_ch.owner_tag = 0;
        req_ch.client_arrival = 0; req_ch.task_bits = 0; req_ch.result_bits = 0;
        req_ch.deadline = 0; req_ch.client_uplink = 1; req_ch.client_downlink = 1;
        calm = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // Reset configuration: zero departure leaves no capacity.
        send_task(1, 16'h0001, 0, 100, 100, 32'hFFFF_FFFF, 1000, 1000);
        drain();
        write_reg(CFG_HARR, 0);
        write_reg(CFG_HDEP, 32'hFFFF_FFFF);
        write_reg(CFG_SPEED, 0);
        write_reg(CFG_HUL, 16'hFFFF);
        write_reg(CFG_HDL, 0);
        drain();
        send_task(0, 16'hFFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
        send_task(1, 16'h0000, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
        send_task(1, 16'h1234, 0, 1, 1, 32'hFFFF_FFFF, 1, 1);
        send_task(0, 16'h5678, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                  16'hFFFF, 16'hFFFF);
        drain();
        write_reg(CFG_SPEED, 16'hFFFF);
        write_reg(CFG_HDL, 16'hFFFF);
        write_reg(CFG_HDEP, 32'h0100_0000);
        write_reg(CFG_HARR, 32'h0000_1000);
        drain();
        // A run of committing tasks whose windows close before they open.
        for (int k = 0; k < 70; k++)
            send_task(1, 16'(k), 32'h10000 * k, 16'hFFFF, 16'd10,
                      32'h10000 * k + 32'h8000, 16'hFFFF, 16'hFFFF);
        send_task(0, 16'hAAAA, 0, 16'hFFFF, 0, 32'h00FF_0000, 16'hFFFF, 16'hFFFF);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            harr = (phase == 0) ? 32'h0 : 32'($urandom_range(32'h0010_0000));
            hdep = (phase == 7) ? 32'hFFFF_FFFF : harr + $urandom_range(32'h0200_0000);
            write_reg(CFG_HARR, harr);
            write_reg(CFG_HDEP, hdep);
            write_reg(CFG_SPEED, phase == 1 ? 16'd1 : 16'($urandom_range(65535, 50)));
            write_reg(CFG_HUL, phase == 2 ? 16'd1 : 16'($urandom_range(65535, 500)));
            write_reg(CFG_HDL, phase == 3 ? 16'hFFFF : 16'($urandom_range(65535, 500)));
            for (int k = 0; k < 100; k++) begin
                calm = (k >= 40 && k < 60);
                send_random(harr, hdep);
            end
            calm = 0;
            drain();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/dwta_pkg.sv
sv/dwta_if.sv
sv/dwta_ram.sv
sv/dwta_div.sv
sv/dwta_front.sv
sv/dwta_fifo.sv
sv/dwta_back.sv
sv/deadline_window_task_admission_top.sv
dv/dwta_checker.sv
dv/deadline_window_task_admission_top_test.sv
